/* rtl/annealing_acceptance_unit_defines.svh */
// ----------------------------------------------------------------------------
// Annealing acceptance unit assertion macros
// Shared concurrent check forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ANNEALING_ACCEPTANCE_UNIT_DEFINES_SVH
`define ANNEALING_ACCEPTANCE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AAU_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("annealing acceptance unit: check failed");

// The consequent must hold in the cycle after the antecedent.
`define AAU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("annealing acceptance unit: check failed");

`endif

/* rtl/aau_pkg.sv */
// ----------------------------------------------------------------------------
// Annealing acceptance unit package
// Widths, register indexes, reset values, command and status types and the
// reciprocal table used by the exponential series.
// ----------------------------------------------------------------------------
`default_nettype none

package aau_pkg;

   localparam int COST_W     = 32;
   localparam int DRAW_W     = 16;
   localparam int RATE_W     = 16;
   localparam int MARGIN_W   = 16;
   localparam int PROB_W     = 17;
   localparam int QUOT_W     = 20;
   localparam int QINT_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W      = 5;
   localparam int K_W        = 4;
   localparam int SEL_W      = 2;

   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_TEMPERATURE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COOLING_RATE        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMPROVE_MARGIN      = 2'd2;

   localparam logic [COST_W-1:0]   TEMP_RESET   = 32'd6553600;
   localparam logic [RATE_W-1:0]   RATE_RESET   = 16'd64880;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd7;
   localparam logic [31:0]         EXP_M1_Q32   = 32'd1580030169;
   localparam logic [PROB_W-1:0]   PROB_ONE     = 17'h1_0000;

   localparam logic [SEL_W-1:0] MUL_TERM_X = 2'd0;
   localparam logic [SEL_W-1:0] MUL_RECIP  = 2'd1;
   localparam logic [SEL_W-1:0] MUL_EXP_M1 = 2'd2;
   localparam logic [SEL_W-1:0] MUL_COOL   = 2'd3;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);
   localparam logic [CNT_W-1:0] K_FIRST  = 5'd2;
   localparam logic [CNT_W-1:0] K_LAST   = 5'd10;
   localparam logic [CNT_W-1:0] CNT_ONE  = 5'd1;

   typedef struct packed {
      logic             load;
      logic             decide;
      logic             div_step;
      logic             series_init;
      logic             mul_en;
      logic [SEL_W-1:0] mul_sel;
      logic             keep_v;
      logic             corr;
      logic             acc_init;
      logic             round;
      logic             prob;
      logic             finish;
      logic [K_W-1:0]   k;
   } aau_cmd_type;

   typedef struct packed {
      logic              need_exp;
      logic [QINT_W-1:0] int_part;
   } aau_status_type;

   // floor(2^32 / k) for the series divisors two to ten.
   function automatic logic [31:0] recip_q32(input logic [K_W-1:0] k);
      logic [31:0] r;
      case (k)
         4'd2:    r = 32'd2147483648;
         4'd3:    r = 32'd1431655765;
         4'd4:    r = 32'd1073741824;
         4'd5:    r = 32'd858993459;
         4'd6:    r = 32'd715827882;
         4'd7:    r = 32'd613566756;
         4'd8:    r = 32'd536870912;
         4'd9:    r = 32'd477218588;
         4'd10:   r = 32'd429496729;
         default: r = 32'hFFFF_FFFF;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/aau_channels.sv */
// ----------------------------------------------------------------------------
// Annealing acceptance unit channels
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface aau_req_if;
   logic                        valid;
   logic                        ready;
   logic [aau_pkg::COST_W-1:0]  candidate_cost;
   logic [aau_pkg::DRAW_W-1:0]  random_draw;
   modport source (output valid, candidate_cost, random_draw, input ready);
   modport sink (input valid, candidate_cost, random_draw, output ready);
endinterface

interface aau_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic                        new_best;
   logic [aau_pkg::COST_W-1:0]  current_cost_out;
   logic [aau_pkg::COST_W-1:0]  best_cost_out;
   logic [aau_pkg::COST_W-1:0]  temperature_out;
   modport source (output valid, accepted, new_best, current_cost_out, best_cost_out,
                   temperature_out, input ready);
   modport sink (input valid, accepted, new_best, current_cost_out, best_cost_out,
                 temperature_out, output ready);
endinterface

interface aau_csr_if;
   logic                            valid;
   logic                            ready;
   logic [aau_pkg::CSR_IDX_W-1:0]   index;
   logic [aau_pkg::CSR_DATA_W-1:0]  wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

/* rtl/aau_ctrl.sv */
// ----------------------------------------------------------------------------
// Annealing acceptance unit controller
// Sequences the comparison, the restoring divider, the exponential series,
// the power loop and the cooling multiply, and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module aau_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  aau_pkg::aau_status_type status,
   output aau_pkg::aau_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_DIV    = 4'd2;
   localparam logic [3:0] S_SINIT  = 4'd3;
   localparam logic [3:0] S_MTX    = 4'd4;
   localparam logic [3:0] S_MRCP   = 4'd5;
   localparam logic [3:0] S_CORR   = 4'd6;
   localparam logic [3:0] S_ACC    = 4'd7;
   localparam logic [3:0] S_MULE   = 4'd8;
   localparam logic [3:0] S_RND    = 4'd9;
   localparam logic [3:0] S_PROB   = 4'd10;
   localparam logic [3:0] S_COOL   = 4'd11;
   localparam logic [3:0] S_FINISH = 4'd12;

   logic [3:0]                   state_ff, state_in;
   logic [aau_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.k        = cnt_ff[aau_pkg::K_W-1:0];
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            cnt_in     = '0;
            state_in   = status.need_exp ? S_DIV : S_COOL;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + aau_pkg::CNT_ONE;
            if (cnt_ff == aau_pkg::DIV_LAST) begin
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            cmd.series_init = 1'b1;
            cnt_in          = aau_pkg::K_FIRST;
            state_in        = S_MTX;
         end
         S_MTX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = aau_pkg::MUL_TERM_X;
            state_in    = S_MRCP;
         end
         S_MRCP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = aau_pkg::MUL_RECIP;
            cmd.keep_v  = 1'b1;
            state_in    = S_CORR;
         end
         S_CORR: begin
            cmd.corr = 1'b1;
            if (cnt_ff == aau_pkg::K_LAST) begin
               state_in = S_ACC;
            end else begin
               cnt_in   = cnt_ff + aau_pkg::CNT_ONE;
               state_in = S_MTX;
            end
         end
         S_ACC: begin
            cmd.acc_init = 1'b1;
            cnt_in       = {1'b0, status.int_part};
            state_in     = (status.int_part == '0) ? S_PROB : S_MULE;
         end
         S_MULE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = aau_pkg::MUL_EXP_M1;
            state_in    = S_RND;
         end
         S_RND: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff - aau_pkg::CNT_ONE;
            state_in  = (cnt_ff == aau_pkg::CNT_ONE) ? S_PROB : S_MULE;
         end
         S_PROB: begin
            cmd.prob = 1'b1;
            state_in = S_COOL;
         end
         S_COOL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = aau_pkg::MUL_COOL;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/aau_datapath.sv */
// ----------------------------------------------------------------------------
// Annealing acceptance unit datapath
// Holds the costs, temperature and registers, a one-bit-per-cycle restoring
// divider, one shared multiplier and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module aau_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [aau_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [aau_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  aau_pkg::aau_cmd_type             cmd,
   output aau_pkg::aau_status_type          status,
   input  logic [aau_pkg::COST_W-1:0]       candidate_cost,
   input  logic [aau_pkg::DRAW_W-1:0]       random_draw,
   output logic                             accepted,
   output logic                             new_best,
   output logic [aau_pkg::COST_W-1:0]       current_cost_out,
   output logic [aau_pkg::COST_W-1:0]       best_cost_out,
   output logic [aau_pkg::COST_W-1:0]       temperature_out
);

   // Architectural state and registers.
   logic [31:0] current_ff, current_in;
   logic [31:0] best_ff, best_in;
   logic [31:0] temp_ff, temp_in;
   logic [15:0] rate_ff, rate_in;
   logic [15:0] margin_ff, margin_in;

   // Working registers.
   logic [31:0] cand_ff, cand_in;
   logic [15:0] draw_ff, draw_in;
   logic        improve_ff, improve_in;
   logic [16:0] prob_ff, prob_in;
   logic [31:0] rem_ff, rem_in;
   logic [19:0] div_lo_ff, div_lo_in;
   logic [19:0] quot_ff, quot_in;
   logic [31:0] term_ff, term_in;
   logic [33:0] pos_ff, pos_in;
   logic [33:0] neg_ff, neg_in;
   logic [32:0] acc_ff, acc_in;
   logic [31:0] v_ff, v_in;
   logic [64:0] prod_ff, prod_in;

   // Response registers.
   logic        out_acc_ff, out_acc_in;
   logic        out_nb_ff, out_nb_in;
   logic [31:0] out_cur_ff, out_cur_in;
   logic [31:0] out_best_ff, out_best_in;
   logic [31:0] out_temp_ff, out_temp_in;

   logic        improve, nonpos, cutoff;
   logic [31:0] diff;
   logic [35:0] twelve_t;
   logic [32:0] trial, trial_sub;
   logic        trial_ge;
   logic [31:0] x_val;
   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] q0;
   logic [35:0] qk, corr_rem;
   logic        corr_fix;
   logic [31:0] term_next;
   logic [64:0] round_sum;
   logic [32:0] prob_sum;
   logic [31:0] cooled, temp_cooled;
   logic        take, best_hit;
   logic [31:0] init_temp;

   assign improve  = ({1'b0, cand_ff} + {17'b0, margin_ff}) < {1'b0, current_ff};
   assign nonpos   = cand_ff <= current_ff;
   assign diff     = cand_ff - current_ff;
   assign twelve_t = {1'b0, temp_ff, 3'b000} + {2'b00, temp_ff, 2'b00};
   assign cutoff   = {4'b0, diff} >= twelve_t;

   assign status.need_exp = !improve && !nonpos && !cutoff;
   assign status.int_part = quot_ff[19:16];

   assign trial     = {rem_ff, div_lo_ff[19]};
   assign trial_sub = trial - {1'b0, temp_ff};
   assign trial_ge  = trial >= {1'b0, temp_ff};

   assign x_val = {quot_ff[15:0], 16'b0};

   always_comb begin
      case (cmd.mul_sel)
         aau_pkg::MUL_TERM_X: begin
            mul_a = {1'b0, term_ff};
            mul_b = x_val;
         end
         aau_pkg::MUL_RECIP: begin
            mul_a = {1'b0, prod_ff[63:32]};
            mul_b = aau_pkg::recip_q32(cmd.k);
         end
         aau_pkg::MUL_EXP_M1: begin
            mul_a = acc_ff;
            mul_b = aau_pkg::EXP_M1_Q32;
         end
         aau_pkg::MUL_COOL: begin
            mul_a = {1'b0, temp_ff};
            mul_b = {16'b0, rate_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Reciprocal quotient is at most one short; a single correction fixes it.
   assign q0        = prod_ff[63:32];
   assign qk        = {4'b0, q0} * {32'b0, cmd.k};
   assign corr_rem  = {4'b0, v_ff} - qk;
   assign corr_fix  = corr_rem >= {32'b0, cmd.k};
   assign term_next = q0 + {31'b0, corr_fix};

   assign round_sum = prod_ff + 65'h0_8000_0000;
   assign prob_sum  = acc_ff + 33'h0_0000_8000;

   assign cooled      = prod_ff[47:16];
   assign temp_cooled = (cooled == '0) ? 32'd1 : cooled;
   assign take        = improve_ff || ({1'b0, draw_ff} < prob_ff);
   assign best_hit    = improve_ff && (cand_ff < best_ff);
   assign init_temp   = (csr_wdata == '0) ? 32'd1 : csr_wdata;

   always_comb begin
      current_in  = current_ff;
      best_in     = best_ff;
      temp_in     = temp_ff;
      rate_in     = rate_ff;
      margin_in   = margin_ff;
      cand_in     = cand_ff;
      draw_in     = draw_ff;
      improve_in  = improve_ff;
      prob_in     = prob_ff;
      rem_in      = rem_ff;
      div_lo_in   = div_lo_ff;
      quot_in     = quot_ff;
      term_in     = term_ff;
      pos_in      = pos_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      v_in        = v_ff;
      prod_in     = prod_ff;
      out_acc_in  = out_acc_ff;
      out_nb_in   = out_nb_ff;
      out_cur_in  = out_cur_ff;
      out_best_in = out_best_ff;
      out_temp_in = out_temp_ff;

      if (cmd.load) begin
         cand_in = candidate_cost;
         draw_in = random_draw;
      end
      if (cmd.decide) begin
         improve_in = improve;
         prob_in    = nonpos ? aau_pkg::PROB_ONE : '0;
         rem_in     = {4'b0, diff[31:4]};
         div_lo_in  = {diff[3:0], 16'b0};
      end
      if (cmd.div_step) begin
         rem_in    = trial_ge ? trial_sub[31:0] : trial[31:0];
         div_lo_in = {div_lo_ff[18:0], 1'b0};
         quot_in   = {quot_ff[18:0], trial_ge};
      end
      if (cmd.series_init) begin
         term_in = x_val;
         neg_in  = {2'b00, x_val};
         pos_in  = 34'h1_0000_0000;
      end
      if (cmd.mul_en) begin
         prod_in = {32'b0, mul_a} * {33'b0, mul_b};
      end
      if (cmd.keep_v) begin
         v_in = prod_ff[63:32];
      end
      if (cmd.corr) begin
         term_in = term_next;
         if (cmd.k[0]) begin
            neg_in = neg_ff + {2'b00, term_next};
         end else begin
            pos_in = pos_ff + {2'b00, term_next};
         end
      end
      if (cmd.acc_init) begin
         acc_in = (pos_ff > neg_ff) ? 33'(pos_ff - neg_ff) : '0;
      end
      if (cmd.round) begin
         acc_in = round_sum[64:32];
      end
      if (cmd.prob) begin
         prob_in = prob_sum[32:16];
      end
      if (cmd.finish) begin
         temp_in     = temp_cooled;
         current_in  = take ? cand_ff : current_ff;
         best_in     = best_hit ? cand_ff : best_ff;
         out_acc_in  = take;
         out_nb_in   = best_hit;
         out_cur_in  = take ? cand_ff : current_ff;
         out_best_in = best_hit ? cand_ff : best_ff;
         out_temp_in = temp_cooled;
      end
      if (csr_write) begin
         case (csr_index)
            aau_pkg::REG_INITIAL_TEMPERATURE: begin
               temp_in    = init_temp;
               current_in = '1;
               best_in    = '1;
            end
            aau_pkg::REG_COOLING_RATE: begin
               rate_in = csr_wdata[15:0];
            end
            aau_pkg::REG_IMPROVE_MARGIN: begin
               margin_in = csr_wdata[15:0];
            end
            default: begin
               rate_in = rate_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '1;
         best_ff    <= '1;
         temp_ff    <= aau_pkg::TEMP_RESET;
         rate_ff    <= aau_pkg::RATE_RESET;
         margin_ff  <= aau_pkg::MARGIN_RESET;
      end else begin
         current_ff <= current_in;
         best_ff    <= best_in;
         temp_ff    <= temp_in;
         rate_ff    <= rate_in;
         margin_ff  <= margin_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      draw_ff     <= draw_in;
      improve_ff  <= improve_in;
      prob_ff     <= prob_in;
      rem_ff      <= rem_in;
      div_lo_ff   <= div_lo_in;
      quot_ff     <= quot_in;
      term_ff     <= term_in;
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      v_ff        <= v_in;
      prod_ff     <= prod_in;
      out_acc_ff  <= out_acc_in;
      out_nb_ff   <= out_nb_in;
      out_cur_ff  <= out_cur_in;
      out_best_ff <= out_best_in;
      out_temp_ff <= out_temp_in;
   end

   assign accepted         = out_acc_ff;
   assign new_best         = out_nb_ff;
   assign current_cost_out = out_cur_ff;
   assign best_cost_out    = out_best_ff;
   assign temperature_out  = out_temp_ff;

endmodule

`default_nettype wire

/* rtl/annealing_acceptance_unit.sv */
// ----------------------------------------------------------------------------
// Annealing acceptance unit
// A candidate that improves, is not worse, or is twelve or more temperatures
// above the current cost goes straight to the cooling multiply. Otherwise the
// 20-step divider, nine series terms (term multiply, reciprocal multiply and
// correction) and i power-loop multiplies run first, where i (0 to 11) is the
// integer part of difference over temperature; all share one multiplier. A new
// request can be taken in the cycle after each response is written. Reset
// restores the register defaults and sets both costs to all ones.
`default_nettype none

`include "annealing_acceptance_unit_defines.svh"

module annealing_acceptance_unit (
   input  logic        clock,
   input  logic        reset,
   aau_req_if.sink     req_if,
   aau_rsp_if.source   rsp_if,
   aau_csr_if.sink     csr_if
);

   aau_pkg::aau_cmd_type    cmd;
   aau_pkg::aau_status_type status;
   logic                    req_ready;
   logic                    rsp_valid;

   assign csr_if.ready = !reset;
   assign req_if.ready = req_ready && !reset;
   assign rsp_if.valid = rsp_valid;

   aau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   aau_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_if.valid),
      .csr_index        (csr_if.index),
      .csr_wdata        (csr_if.wdata),
      .cmd              (cmd),
      .status           (status),
      .candidate_cost   (req_if.candidate_cost),
      .random_draw      (req_if.random_draw),
      .accepted         (rsp_if.accepted),
      .new_best         (rsp_if.new_best),
      .current_cost_out (rsp_if.current_cost_out),
      .best_cost_out    (rsp_if.best_cost_out),
      .temperature_out  (rsp_if.temperature_out)
   );

   `AAU_ASSERT_NEXT(one_item_a, req_if.valid && req_ready, !req_ready)
   `AAU_ASSERT_SAME(temp_floor_a, rsp_valid, rsp_if.temperature_out != '0)
   `AAU_ASSERT_SAME(best_is_accepted_a, rsp_valid && rsp_if.new_best, rsp_if.accepted)

endmodule

`default_nettype wire

/* tb/aau_acceptance_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annealing acceptance checker
// Watches the register, candidate and verdict channels of the acceptance unit.
// It keeps its own copy of the registers, costs and temperature, and works
// out the verdict of every accepted candidate transaction. Each verdict
// transaction is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module aau_acceptance_checker (
   input  logic                      clock,
   input  logic                      reset,
   aau_req_if                        req_ch,
   aau_rsp_if                        rsp_ch,
   aau_csr_if                        csr_ch,
   output int                        mismatches,
   output int                        outstanding,
   output logic [aau_pkg::COST_W-1:0] cost_now,
   output logic [aau_pkg::COST_W-1:0] temp_now
);
   import aau_pkg::*;

   localparam int          SERIES_LEN = 10;
   localparam logic [63:0] CUTOFF     = 64'd12;
   localparam logic [63:0] Q32_ONE    = 64'h1_0000_0000;

   typedef struct packed {
      logic              accepted;
      logic              new_best;
      logic [COST_W-1:0] current_cost;
      logic [COST_W-1:0] best_cost;
      logic [COST_W-1:0] temperature;
   } outcome_t;

   outcome_t          outcomes_due[$];
   outcome_t          oldest;
   logic [COST_W-1:0] start_temp;
   logic [RATE_W-1:0] cool_rate;
   logic [MARGIN_W-1:0] margin;
   logic [COST_W-1:0] current;
   logic [COST_W-1:0] best;
   logic [COST_W-1:0] temperature;

   function automatic logic [63:0] boltzmann_q16(logic [63:0] ratio);
      logic [63:0] whole, x, term, pos, neg, acc;
      whole = ratio >> 16;
      x     = (ratio & 64'hFFFF) << 16;
      term  = Q32_ONE;
      pos   = Q32_ONE;
      neg   = '0;
      for (int k = 1; k <= SERIES_LEN; k++) begin
         term = ((term * x) >> 32) / 64'(k);
         if (k % 2 == 1) begin
            neg += term;
         end else begin
            pos += term;
         end
      end
      acc = (pos > neg) ? pos - neg : '0;
      for (logic [63:0] n = 0; n < whole; n++) begin
         acc = (acc * 64'(EXP_M1_Q32) + 64'h8000_0000) >> 32;
      end
      return (acc + 64'h8000) >> 16;
   endfunction

   function automatic outcome_t metropolis_step(logic [COST_W-1:0] cand,
                                                logic [DRAW_W-1:0] draw);
      outcome_t    v;
      logic [63:0] diff, prob, cooled;
      v.accepted = 1'b0;
      v.new_best = 1'b0;
      if (64'(cand) + 64'(margin) < 64'(current)) begin
         v.accepted = 1'b1;
         current    = cand;
         if (cand < best) begin
            best       = cand;
            v.new_best = 1'b1;
         end
      end else begin
         if (cand <= current) begin
            prob = 64'(PROB_ONE);
         end else begin
            diff = 64'(cand) - 64'(current);
            if (diff >= CUTOFF * 64'(temperature)) begin
               prob = '0;
            end else begin
               prob = boltzmann_q16((diff << 16) / 64'(temperature));
            end
         end
         if (64'(draw) < prob) begin
            v.accepted = 1'b1;
            current    = cand;
         end
      end
      cooled      = (64'(temperature) * 64'(cool_rate)) >> 16;
      temperature = (cooled[COST_W-1:0] == '0) ? COST_W'(1) : cooled[COST_W-1:0];
      v.current_cost = current;
      v.best_cost    = best;
      v.temperature  = temperature;
      return v;
   endfunction

   function automatic void check_field(string label, logic [COST_W-1:0] want,
                                       logic [COST_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, label, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start_temp  = TEMP_RESET;
         cool_rate   = RATE_RESET;
         margin      = MARGIN_RESET;
         temperature = TEMP_RESET;
         current     = '1;
         best        = '1;
         outcomes_due.delete();
         mismatches  = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_INITIAL_TEMPERATURE: begin
                  start_temp  = (csr_ch.wdata == '0) ? COST_W'(1) : csr_ch.wdata;
                  temperature = start_temp;
                  current     = '1;
                  best        = '1;
               end
               REG_COOLING_RATE: begin
                  cool_rate = csr_ch.wdata[RATE_W-1:0];
               end
               REG_IMPROVE_MARGIN: begin
                  margin = csr_ch.wdata[MARGIN_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            outcomes_due = {outcomes_due, metropolis_step(req_ch.candidate_cost,
                                                          req_ch.random_draw)};
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcomes_due.size() == 0) begin
               $display("%0t: verdict with none pending, expected none actual %h",
                        $time, rsp_ch.current_cost_out);
               mismatches++;
            end else begin
               oldest = outcomes_due.pop_front();
               check_field("accepted", COST_W'(oldest.accepted), COST_W'(rsp_ch.accepted));
               check_field("new_best", COST_W'(oldest.new_best), COST_W'(rsp_ch.new_best));
               check_field("current_cost_out", oldest.current_cost, rsp_ch.current_cost_out);
               check_field("best_cost_out", oldest.best_cost, rsp_ch.best_cost_out);
               check_field("temperature_out", oldest.temperature, rsp_ch.temperature_out);
            end
         end
      end
      outstanding = outcomes_due.size();
      cost_now    = current;
      temp_now    = temperature;
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annealing acceptance unit testbench
// Drives candidate transactions and register writes into the acceptance unit,
// with random idling on the candidate and verdict channels, and gives the
// verdict from the checker's failure count. A directed part covers the extremes
// and the special cases; random blocks then run under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
   import aau_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int                   BLOCKS    = 7;
   localparam int                   PER_BLOCK = 100;
   localparam logic [COST_W-1:0]    COST_MAX  = '1;

   logic              clock = 1'b0;
   logic              reset;
   int                tx_idle;
   int                rx_idle;
   int                mismatches;
   int                outstanding;
   logic [COST_W-1:0] cost_now;
   logic [COST_W-1:0] temp_now;

   aau_req_if candidate_ch ();
   aau_rsp_if verdict_ch ();
   aau_csr_if csr_ch ();

   annealing_acceptance_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (candidate_ch),
      .rsp_if (verdict_ch),
      .csr_if (csr_ch)
   );

   aau_acceptance_checker acceptance_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (candidate_ch),
      .rsp_ch      (verdict_ch),
      .csr_ch      (csr_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .cost_now    (cost_now),
      .temp_now    (temp_now)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      verdict_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
   end

   function automatic logic [COST_W-1:0] cost_above(logic [63:0] delta);
      logic [63:0] sum;
      sum = 64'(cost_now) + delta;
      return (sum > 64'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pad_upper(logic [15:0] value);
      logic [31:0] noise;
      noise = $urandom;
      return {noise[31:16], value};
   endfunction

   task automatic send_candidate(logic [COST_W-1:0] cost, logic [DRAW_W-1:0] draw);
      while ($urandom_range(0, 99) < tx_idle) begin
         candidate_ch.valid <= 1'b0;
         @(negedge clock);
      end
      candidate_ch.valid          <= 1'b1;
      candidate_ch.candidate_cost <= cost;
      candidate_ch.random_draw    <= draw;
      @(posedge clock);
      while (!candidate_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      candidate_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [63:0]         span, head, lim;
      logic [COST_W-1:0]   cand, t0;
      logic [RATE_W-1:0]   rate;
      logic [MARGIN_W-1:0] margin;
      logic [DRAW_W-1:0]   draw;
      int                  sel;

      reset                       = 1'b1;
      candidate_ch.valid          = 1'b0;
      candidate_ch.candidate_cost = '0;
      candidate_ch.random_draw    = '0;
      verdict_ch.ready            = 1'b0;
      csr_ch.valid                = 1'b0;
      csr_ch.index                = REG_INITIAL_TEMPERATURE;
      csr_ch.wdata                = '0;
      tx_idle                     = 33;
      rx_idle                     = 84;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings first: equal, within-margin, improving and cut-off candidates.
      send_candidate(COST_MAX, 16'hFFFF);
      send_candidate(32'h8000_0000, 16'hFFFF);
      send_candidate(32'h8000_0003, 16'hFFFF);
      send_candidate(cost_above(64'd0), '0);
      send_candidate(cost_above(64'(temp_now) * 64'd12), '0);
      send_candidate(cost_above(64'(temp_now) * 64'd12 - 64'd1), '0);
      send_candidate(cost_above(64'(temp_now)), 16'hFFFF);
      send_candidate(cost_above(64'(temp_now)), '0);
      send_candidate(cost_above(64'(temp_now) / 64'd2), 16'h8000);
      send_candidate('0, 16'hFFFF);
      send_candidate('0, '0);
      send_candidate(COST_MAX, '0);

      // A zero cooling rate and a zero start temperature both leave one LSB.
      write_reg(REG_COOLING_RATE, pad_upper('0));
      write_reg(REG_IMPROVE_MARGIN, pad_upper('0));
      write_reg(REG_SPARE, $urandom);
      write_reg(REG_INITIAL_TEMPERATURE, '0);
      send_candidate(32'd5, '0);
      send_candidate(32'd6, '0);
      send_candidate(cost_above(64'd11), '0);
      send_candidate(cost_above(64'd12), '0);

      write_reg(REG_INITIAL_TEMPERATURE, COST_MAX);
      write_reg(REG_COOLING_RATE, pad_upper(16'hFFFF));
      write_reg(REG_IMPROVE_MARGIN, pad_upper(16'hFFFF));
      send_candidate(32'h0001_0000, '0);
      send_candidate(cost_now - 32'h0000_FFFF, 16'hFFFF);
      send_candidate(cost_above(64'h0FFF_FFFF), 16'hFFFF);
      send_candidate(COST_MAX, 16'h7FFF);

      for (int blk = 0; blk < BLOCKS; blk++) begin
         tx_idle = (blk < 2) ? 33 : (blk < 4) ? 84 : 0;
         rx_idle = (blk < 2) ? 84 : (blk < 4) ? 33 : 0;
         case (blk)
            0: begin
               t0 = TEMP_RESET; rate = RATE_RESET; margin = MARGIN_RESET;
            end
            1: begin
               t0 = COST_MAX; rate = 16'hFFFF; margin = 16'hFFFF;
            end
            2: begin
               t0     = $urandom_range(1, 32'h0100_0000);
               rate   = 16'($urandom_range(60000, 65535));
               margin = 16'($urandom_range(0, 64));
            end
            3: begin
               t0 = '0; rate = 16'hFFFF; margin = '0;
            end
            4: begin
               t0     = $urandom_range(32'h0001_0000, 32'h0400_0000);
               rate   = '0;
               margin = 16'($urandom_range(0, 255));
            end
            5: begin
               t0 = 32'h0001_0000; rate = 16'd65000; margin = 16'd3;
            end
            default: begin
               t0 = $urandom; rate = 16'($urandom); margin = 16'($urandom);
            end
         endcase
         write_reg(REG_COOLING_RATE, pad_upper(rate));
         write_reg(REG_IMPROVE_MARGIN, pad_upper(margin));
         write_reg(REG_INITIAL_TEMPERATURE, t0);

         for (int n = 0; n < PER_BLOCK; n++) begin
            sel  = $urandom_range(0, 99);
            span = 64'(temp_now) * 64'd12;
            head = 64'(COST_MAX) - 64'(cost_now);
            if (sel < 10) begin
               cand = $urandom;
            end else if (sel < 25) begin
               if ($urandom_range(0, 1) == 1) begin
                  lim = 64'($urandom_range(0, 16));
               end else begin
                  lim = 64'($urandom_range(0, cost_now));
               end
               cand = (lim > 64'(cost_now)) ? '0 : cost_now - lim[COST_W-1:0];
            end else if (sel < 85 && head != 0) begin
               lim  = (span - 64'd1 < head) ? span - 64'd1 : head;
               cand = cost_now + $urandom_range(1, lim[31:0]);
            end else begin
               case ($urandom_range(0, 3))
                  0:       cand = cost_now;
                  1:       cand = cost_above(span);
                  2:       cand = cost_above(span - 64'd1);
                  default: cand = cost_above(64'd1);
               endcase
            end
            sel  = $urandom_range(0, 9);
            draw = (sel == 0) ? '0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            send_candidate(cand, draw);
         end
      end

      candidate_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/aau_pkg.sv
rtl/aau_channels.sv
rtl/aau_ctrl.sv
rtl/aau_datapath.sv
rtl/annealing_acceptance_unit.sv
tb/aau_acceptance_checker.sv
tb/tb_top.sv
